FILE: hw/rtl/tpsp_pkg.sv
// Shared types and constants of the synchronized trapezoidal profile planner.
package tpsp_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL1,
        S_T_MUL2,
        S_T_CMP,
        S_T_DIVQ,
        S_T_SQRT,
        S_T_DIVR,
        S_T_DIVC,
        S_T_NEXT,
        S_R_SEL,
        S_R_DIVS,
        S_R_DIVA,
        S_R_DIVX,
        S_R_DIVB,
        S_R_MUL,
        S_R_CHK,
        S_R_EMIT
    } tpsp_state_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_TRAP = 2'd0;
    localparam kind_t KIND_BANG = 2'd1;
    localparam kind_t KIND_NONE = 2'd2;

    localparam int JOINT_LIMIT = 8;

endpackage

FILE: hw/rtl/trapezoid_profile_sync_planner.sv
// Top level of the synchronized trapezoidal profile planner with its sequencer and datapath.
// A joint request is loaded while the block is idle; a request with last_joint starts planning.
// Planning runs on one shared bit-serial divider (one quotient bit per cycle, NW = 64 at
// FRAC_BITS = 16), a 32-step root unit and a 33x32 multiplier.
// A timing pass over the joints is followed by a refit pass with one result strobe per joint
// that the receiver cannot stall; busy stays high.
// Reset clears the sequencer, the joint count and the timing registers; the stores are not cleared.
module trapezoid_profile_sync_planner
    import tpsp_pkg::*;
#(
    parameter int MAX_JOINTS = 8,
    parameter int FRAC_BITS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] current_position,
    input  logic signed [31:0] target_position,
    input  logic        [31:0] speed_limit,
    input  logic        [31:0] accel_limit,
    input  logic               last_joint,
    output logic               done,
    output logic        [2:0]  joint_number,
    output logic        [1:0]  profile_kind,
    output logic               is_leader,
    output logic        [31:0] cruise_speed,
    output logic        [31:0] acceleration,
    output logic        [31:0] total_time,
    output logic        [31:0] accel_time,
    output logic               last_result
);

    localparam int CAP = (MAX_JOINTS < JOINT_LIMIT) ? MAX_JOINTS : JOINT_LIMIT;
    localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW  = $clog2(CAP + 1);
    localparam int NW  = (2 * FRAC_BITS + 32 > 64) ? 2 * FRAC_BITS + 32 : 64;
    localparam int DCW = $clog2(NW + 1);

    tpsp_state_t state_reg, state_next;

    logic [31:0] path_store_reg  [CAP];
    logic [31:0] speed_store_reg [CAP];
    logic [31:0] accel_store_reg [CAP];

    logic [CW-1:0]  cnt_reg, n_reg;
    logic [IW-1:0]  i_reg;
    logic [31:0]    longest_reg, lat_reg;
    logic [IW-1:0]  lidx_reg;
    logic           lkind_reg;
    logic           failed_reg;

    logic [31:0]    t_reg, ta_reg;
    logic           bang_reg;
    logic [32:0]    tr_reg;
    logic [63:0]    vv_reg;
    logic [64:0]    prod_reg;

    logic [NW-1:0]  div_quo_reg;
    logic [31:0]    div_rem_reg, div_den_reg;
    logic [DCW-1:0] div_cnt_reg;

    logic [63:0]    rt_x_reg, rt_res_reg, rt_bit_reg;

    kind_t          kind_reg;
    logic           lead_reg;
    logic [31:0]    spd_reg, acc_reg;

    logic [31:0]    p_w, v_w, a_w;
    logic           div_done, rt_done, is_last, div_load, div_state;
    logic [NW-1:0]  div_num_w;
    logic [31:0]    div_den_w;
    logic [32:0]    mul_a_w;
    logic [31:0]    mul_b_w;
    logic [32:0]    rem_sh_w;
    logic [63:0]    rt_sum_w;
    logic [32:0]    path_w;
    logic [32:0]    diff_w;
    logic           big_q, big_x, s_ok, ac_ok, s2_ok;
    logic [32:0]    tc_sat_w;
    logic [33:0]    tsum_w;
    logic [CW-1:0]  n_new_w;

    assign p_w      = path_store_reg[i_reg];
    assign v_w      = speed_store_reg[i_reg];
    assign a_w      = accel_store_reg[i_reg];
    assign div_done = (div_cnt_reg == '0);
    assign rt_done  = (rt_bit_reg == '0);
    assign is_last  = ((CW'(i_reg) + CW'(1)) == n_reg);

    assign big_q = (div_quo_reg[NW-1:62] != '0);
    assign big_x = (div_quo_reg[NW-1:64-FRAC_BITS] != '0);
    assign s_ok  = (div_quo_reg <= NW'(v_w));
    assign ac_ok = (div_quo_reg <= NW'(a_w));
    assign s2_ok = ((prod_reg >> FRAC_BITS) <= 65'(v_w));

    assign tc_sat_w = (div_quo_reg[NW-1:32] != '0) ? 33'h1_0000_0000
                                                   : {1'b0, div_quo_reg[31:0]};
    assign tsum_w   = {1'b0, tr_reg} + {1'b0, tc_sat_w};

    assign diff_w  = 33'(target_position) - 33'(current_position);
    assign path_w  = diff_w[32] ? (33'd0 - diff_w) : diff_w;
    assign n_new_w = (cnt_reg < CW'(CAP)) ? cnt_reg + CW'(1) : cnt_reg;

    assign rem_sh_w = {div_rem_reg, div_quo_reg[NW-1]};
    assign rt_sum_w = rt_res_reg + rt_bit_reg;

    always_comb
    begin
        case (state_next)
            S_T_DIVQ, S_T_DIVR, S_T_DIVC, S_R_DIVS, S_R_DIVA, S_R_DIVX, S_R_DIVB:
                div_state = 1'b1;
            default: div_state = 1'b0;
        endcase
    end
    assign div_load = div_state && (state_next != state_reg);

    always_comb
    begin
        case (state_next)
            S_T_DIVQ:
            begin
                div_num_w = NW'(p_w) << (2 * FRAC_BITS);
                div_den_w = a_w;
            end
            S_T_DIVR:
            begin
                div_num_w = NW'(p_w) << FRAC_BITS;
                div_den_w = v_w;
            end
            S_T_DIVC:
            begin
                div_num_w = NW'(v_w) << FRAC_BITS;
                div_den_w = a_w;
            end
            S_R_DIVS:
            begin
                div_num_w = NW'(p_w) << FRAC_BITS;
                div_den_w = longest_reg - lat_reg;
            end
            S_R_DIVA, S_R_DIVB:
            begin
                div_num_w = div_quo_reg << FRAC_BITS;
                div_den_w = lat_reg;
            end
            S_R_DIVX:
            begin
                div_num_w = NW'(p_w) << FRAC_BITS;
                div_den_w = lat_reg;
            end
            default:
            begin
                div_num_w = '0;
                div_den_w = 32'd1;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_T_MUL1:
            begin
                mul_a_w = {1'b0, v_w};
                mul_b_w = v_w;
            end
            S_T_MUL2:
            begin
                mul_a_w = {1'b0, p_w} + 33'd1;
                mul_b_w = a_w;
            end
            default:
            begin
                mul_a_w = {1'b0, acc_reg};
                mul_b_w = lat_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && last_joint)
                begin
                    state_next = S_T_MUL1;
                end
            end
            S_T_MUL1: state_next = (p_w == '0) ? S_T_NEXT : S_T_MUL2;
            S_T_MUL2: state_next = S_T_CMP;
            S_T_CMP:  state_next = (65'(vv_reg) >= prod_reg) ? S_T_DIVQ : S_T_DIVR;
            S_T_DIVQ:
            begin
                if (div_done)
                begin
                    state_next = big_q ? S_T_NEXT : S_T_SQRT;
                end
            end
            S_T_SQRT:
            begin
                if (rt_done)
                begin
                    state_next = S_T_NEXT;
                end
            end
            S_T_DIVR:
            begin
                if (div_done)
                begin
                    state_next = S_T_DIVC;
                end
            end
            S_T_DIVC:
            begin
                if (div_done)
                begin
                    state_next = S_T_NEXT;
                end
            end
            S_T_NEXT: state_next = is_last ? S_R_SEL : S_T_MUL1;
            S_R_SEL:
            begin
                if (longest_reg == '0 || p_w == '0 || i_reg == lidx_reg || failed_reg
                    || lat_reg == '0)
                begin
                    state_next = S_R_EMIT;
                end
                else if (longest_reg > lat_reg)
                begin
                    state_next = S_R_DIVS;
                end
                else
                begin
                    state_next = S_R_DIVX;
                end
            end
            S_R_DIVS:
            begin
                if (div_done)
                begin
                    state_next = s_ok ? S_R_DIVA : S_R_DIVX;
                end
            end
            S_R_DIVA:
            begin
                if (div_done)
                begin
                    state_next = ac_ok ? S_R_EMIT : S_R_DIVX;
                end
            end
            S_R_DIVX:
            begin
                if (div_done)
                begin
                    state_next = big_x ? S_R_EMIT : S_R_DIVB;
                end
            end
            S_R_DIVB:
            begin
                if (div_done)
                begin
                    state_next = ac_ok ? S_R_MUL : S_R_EMIT;
                end
            end
            S_R_MUL:  state_next = S_R_CHK;
            S_R_CHK:  state_next = S_R_EMIT;
            S_R_EMIT: state_next = is_last ? S_IDLE : S_R_SEL;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_R_EMIT);
    end

    assign joint_number = 3'(i_reg);
    assign profile_kind = kind_reg;
    assign is_leader    = lead_reg;
    assign cruise_speed = spd_reg;
    assign acceleration = acc_reg;
    assign total_time   = longest_reg;
    assign accel_time   = lat_reg;
    assign last_result  = is_last;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && cnt_reg < CW'(CAP))
        begin
            path_store_reg[cnt_reg[IW-1:0]]  <= path_w[31:0];
            speed_store_reg[cnt_reg[IW-1:0]] <= (speed_limit == '0) ? 32'd1 : speed_limit;
            accel_store_reg[cnt_reg[IW-1:0]] <= (accel_limit == '0) ? 32'd1 : accel_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            n_reg       <= '0;
            i_reg       <= '0;
            longest_reg <= '0;
            lat_reg     <= '0;
            lidx_reg    <= '0;
            lkind_reg   <= 1'b0;
            failed_reg  <= 1'b0;
            div_cnt_reg <= '0;
            rt_bit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (div_load)
            begin
                div_cnt_reg <= DCW'(NW);
            end
            else if (!div_done)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end

            if (state_next == S_T_SQRT && state_reg != S_T_SQRT)
            begin
                rt_bit_reg <= 64'h4000_0000_0000_0000;
            end
            else if (!rt_done)
            begin
                rt_bit_reg <= rt_bit_reg >> 2;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (last_joint)
                        begin
                            n_reg       <= n_new_w;
                            cnt_reg     <= '0;
                            i_reg       <= '0;
                            longest_reg <= '0;
                            lat_reg     <= '0;
                            lidx_reg    <= '0;
                            lkind_reg   <= 1'b0;
                            failed_reg  <= 1'b0;
                        end
                        else
                        begin
                            cnt_reg <= n_new_w;
                        end
                    end
                end
                S_T_NEXT:
                begin
                    if (t_reg > longest_reg)
                    begin
                        longest_reg <= t_reg;
                        lat_reg     <= ta_reg;
                        lidx_reg    <= i_reg;
                        lkind_reg   <= bang_reg;
                    end
                    i_reg <= is_last ? '0 : i_reg + IW'(1);
                end
                S_R_SEL:
                begin
                    if (longest_reg != '0 && p_w != '0 && i_reg != lidx_reg && !failed_reg
                        && lat_reg == '0)
                    begin
                        failed_reg <= 1'b1;
                    end
                end
                S_R_DIVX:
                begin
                    if (div_done && big_x)
                    begin
                        failed_reg <= 1'b1;
                    end
                end
                S_R_DIVB:
                begin
                    if (div_done && !ac_ok)
                    begin
                        failed_reg <= 1'b1;
                    end
                end
                S_R_CHK:
                begin
                    if (!s2_ok)
                    begin
                        failed_reg <= 1'b1;
                    end
                end
                S_R_EMIT:
                begin
                    i_reg <= is_last ? '0 : i_reg + IW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_quo_reg <= div_num_w;
            div_rem_reg <= '0;
            div_den_reg <= div_den_w;
        end
        else if (!div_done)
        begin
            if (rem_sh_w >= {1'b0, div_den_reg})
            begin
                div_rem_reg <= 32'(rem_sh_w - {1'b0, div_den_reg});
                div_quo_reg <= {div_quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= rem_sh_w[31:0];
                div_quo_reg <= {div_quo_reg[NW-2:0], 1'b0};
            end
        end

        if (state_next == S_T_SQRT && state_reg != S_T_SQRT)
        begin
            rt_x_reg   <= div_quo_reg[63:0];
            rt_res_reg <= '0;
        end
        else if (!rt_done)
        begin
            if (rt_x_reg >= rt_sum_w)
            begin
                rt_x_reg   <= rt_x_reg - rt_sum_w;
                rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
            end
            else
            begin
                rt_res_reg <= rt_res_reg >> 1;
            end
        end

        case (state_reg)
            S_T_MUL1, S_T_MUL2, S_R_MUL:
            begin
                prod_reg <= mul_a_w * mul_b_w;
            end
            default:
            begin
            end
        endcase

        case (state_reg)
            S_T_MUL1:
            begin
                t_reg    <= '0;
                ta_reg   <= '0;
                bang_reg <= 1'b0;
            end
            S_T_MUL2:
            begin
                vv_reg <= prod_reg[63:0];
            end
            S_T_CMP:
            begin
                bang_reg <= (65'(vv_reg) >= prod_reg);
            end
            S_T_DIVQ:
            begin
                if (div_done && big_q)
                begin
                    t_reg  <= 32'hFFFF_FFFF;
                    ta_reg <= 32'h7FFF_FFFF;
                end
            end
            S_T_SQRT:
            begin
                if (rt_done)
                begin
                    t_reg  <= {rt_res_reg[30:0], 1'b0};
                    ta_reg <= rt_res_reg[31:0];
                end
            end
            S_T_DIVR:
            begin
                if (div_done)
                begin
                    tr_reg <= (div_quo_reg[NW-1:32] != '0) ? 33'h1_0000_0000
                                                            : {1'b0, div_quo_reg[31:0]};
                end
            end
            S_T_DIVC:
            begin
                if (div_done)
                begin
                    t_reg  <= (tsum_w[33:32] != 2'b00) ? 32'hFFFF_FFFF : tsum_w[31:0];
                    ta_reg <= tc_sat_w[32] ? 32'hFFFF_FFFF : tc_sat_w[31:0];
                end
            end
            S_R_SEL:
            begin
                kind_reg <= KIND_NONE;
                lead_reg <= 1'b0;
                spd_reg  <= '0;
                acc_reg  <= '0;
                if (longest_reg != '0 && p_w != '0 && i_reg == lidx_reg)
                begin
                    kind_reg <= lkind_reg ? KIND_BANG : KIND_TRAP;
                    lead_reg <= 1'b1;
                    spd_reg  <= v_w;
                    acc_reg  <= a_w;
                end
            end
            S_R_DIVS:
            begin
                if (div_done && s_ok)
                begin
                    spd_reg <= div_quo_reg[31:0];
                end
            end
            S_R_DIVA:
            begin
                if (div_done)
                begin
                    if (ac_ok)
                    begin
                        acc_reg  <= div_quo_reg[31:0];
                        kind_reg <= KIND_TRAP;
                    end
                    else
                    begin
                        spd_reg <= '0;
                    end
                end
            end
            S_R_DIVB:
            begin
                if (div_done)
                begin
                    if (ac_ok)
                    begin
                        acc_reg <= div_quo_reg[31:0];
                    end
                    else
                    begin
                        spd_reg <= '0;
                        acc_reg <= '0;
                    end
                end
            end
            S_R_CHK:
            begin
                if (s2_ok)
                begin
                    spd_reg  <= 32'(prod_reg >> FRAC_BITS);
                    kind_reg <= KIND_BANG;
                end
                else
                begin
                    spd_reg <= '0;
                    acc_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/tpsp_checker.sv
// Port-level checker of the planner and its bind to the top level.
module tpsp_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_joint,
    input logic done,
    input logic last_result
);

    // A result strobe only appears while a plan is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while not busy");

    // A request without last_joint only loads and leaves the block free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_joint) |=> !busy)
        else $error("block became busy after a plain load");

    // A request with last_joint starts planning.
    a_plan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_joint) |=> busy)
        else $error("planning did not start");

    // The final result ends the plan.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_result) |=> !busy)
        else $error("block still busy after the final result");

endmodule

bind trapezoid_profile_sync_planner tpsp_checker u_tpsp_checker (.*);
